/* design/ebu_pkg.sv */
// ----------------------------------------------------------------------------
// ebu_pkg
// Shared types and codes for the escape byte unstuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ebu_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFlagByte   = 3'd0,
    CfgEscapeByte = 3'd1,
    CfgFlagCode   = 3'd2,
    CfgEscapeCode = 3'd3,
    CfgMaxLength  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadEsc   = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        packet_done;
    logic [15:0] out_length;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  flag_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  flag_code;
    logic [7:0]  escape_code;
    logic [15:0] max_length;
  } cfg_t;

  // byte after classification, as it sits in the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_escape;
    logic       is_flag_code;
    logic       is_escape_code;
  } cls_item_t;

  localparam cfg_t CfgReset = '{
    flag_byte:   8'd126,
    escape_byte: 8'd125,
    flag_code:   8'd2,
    escape_code: 8'd1,
    max_length:  16'hFFFF
  };

endpackage

`default_nettype wire

/* design/ebu_front.sv */
// ----------------------------------------------------------------------------
// ebu_front
// Accepts stuffed bytes and tags them against the escape byte and codes.
// ----------------------------------------------------------------------------
`default_nettype none

module ebu_front import ebu_pkg::*; (
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  input  wire cfg_t      cfg_i,
  input  wire logic      q_full_i,
  output logic           push_o,
  output cls_item_t      push_item_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    push_item_o.data_byte      = in_item_i.data_byte;
    push_item_o.last_byte      = in_item_i.last_byte;
    push_item_o.is_escape      = (in_item_i.data_byte == cfg_i.escape_byte);
    push_item_o.is_flag_code   = (in_item_i.data_byte == cfg_i.flag_code);
    push_item_o.is_escape_code = (in_item_i.data_byte == cfg_i.escape_code);
  end

endmodule

`default_nettype wire

/* design/ebu_queue.sv */
// ----------------------------------------------------------------------------
// ebu_queue
// Small FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ebu_queue import ebu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire cls_item_t push_item_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output cls_item_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cls_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* design/ebu_back.sv */
// ----------------------------------------------------------------------------
// ebu_back
// Escape state, length count and error tracking; registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module ebu_back import ebu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      q_valid_i,
  input  wire cls_item_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic        pend_q, pend_d;
  logic [15:0] count_q, count_d;
  status_e     err_q, err_d;
  logic        out_valid_q;
  out_item_t   out_q, res;
  logic        have;
  logic [7:0]  val;

  // output register frees up when empty or being taken this cycle
  assign pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    pend_d  = pend_q;
    count_d = count_q;
    err_d   = err_q;
    have    = 1'b0;
    val     = 8'd0;

    if (err_q == StOk) begin
      if (pend_q) begin
        pend_d = 1'b0;
        if (q_head_i.is_flag_code) begin
          have = 1'b1;
          val  = cfg_i.flag_byte;
        end else if (q_head_i.is_escape_code) begin
          have = 1'b1;
          val  = cfg_i.escape_byte;
        end else begin
          err_d = StBadEsc;
        end
      end else if (q_head_i.is_escape) begin
        pend_d = 1'b1;
      end else begin
        have = 1'b1;
        val  = q_head_i.data_byte;
      end
      if (have) begin
        if (count_q < cfg_i.max_length) begin
          count_d = count_q + 16'd1;
        end else begin
          have  = 1'b0;
          val   = 8'd0;
          err_d = StOverflow;
        end
      end
    end

    res.byte_valid  = have;
    res.out_byte    = val;
    res.packet_done = q_head_i.last_byte;
    res.out_length  = (q_head_i.last_byte && err_d == StOk) ? count_d : 16'd0;
    res.status      = q_head_i.last_byte ? err_d : StOk;

    if (q_head_i.last_byte) begin
      pend_d  = 1'b0;
      count_d = 16'd0;
      err_d   = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      count_q     <= 16'd0;
      err_q       <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        pend_q      <= pend_d;
        count_q     <= count_d;
        err_q       <= err_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

/* design/escape_byte_unstuffer.sv */
// ----------------------------------------------------------------------------
// escape_byte_unstuffer
// Removes escape stuffing from a packet body, one stuffed byte per request.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o | in_item_i   (data_byte, last_byte)
//  out     | out_valid_o/out_stall_i | out_item_o  (byte_valid .. status)
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One request per clock sustained while out_stall_i is low; one result per
//  request. A request is written into the queue, then the state update loads
//  the output register. The throughput is set by the escape state loop.
//  Reset clears escape state, count, error, queue and output valid; the
//  registers return to their default values. The input stalls only when the
//  queue is full; a valid output register holds while out_stall_i is high.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_byte_unstuffer import ebu_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      push, q_full, q_valid, pop;
  cls_item_t push_item, q_head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFlagByte:   cfg_q.flag_byte   <= cfg_data_i[7:0];
        CfgEscapeByte: cfg_q.escape_byte <= cfg_data_i[7:0];
        CfgFlagCode:   cfg_q.flag_code   <= cfg_data_i[7:0];
        CfgEscapeCode: cfg_q.escape_code <= cfg_data_i[7:0];
        CfgMaxLength:  cfg_q.max_length  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ebu_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  ebu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  ebu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
